// File: rtl/laser_plane_ray_intersect_defines.svh
// assertion macros for the laser plane ray intersection block
`ifndef LASER_PLANE_RAY_INTERSECT_DEFINES_SVH
`define LASER_PLANE_RAY_INTERSECT_DEFINES_SVH

// antecedent implies consequent on the next clock
`define LPRI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// antecedent implies consequent a fixed number of clocks later
`define LPRI_ASSERT_DELAY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
        else $error(msg);

`endif

// File: rtl/lpri_pkg.sv
// shared types, constants and rounding helper for the laser plane intersection block
`default_nettype none

package lpri_pkg;

    localparam int FRAC_BITS = 16;
    localparam int UNIT_BITS = 30;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_X       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Y       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_Z       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANE_DISTANCE = 2'd3;

    localparam logic signed [31:0] SAT_POS = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_NEG = 32'sh8000_0000;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;

    typedef struct packed {
        logic signed [31:0] ray_x;
        logic signed [31:0] ray_y;
    } ray_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic               overflow;
    } point_t;

    // plane-derived coefficients, Q30 (distance is the raw register, deg a flag)
    typedef struct packed {
        logic signed [32:0] a;
        logic signed [32:0] b;
        logic signed [32:0] c;
        logic signed [31:0] u1;
        logic signed [31:0] u2;
        logic [30:0]        distance;
        logic               deg;
    } coef_t;

    typedef struct packed {
        ray_t ray;
        logic deg;
    } item_t;

    // shift right with rounding half away from zero
    function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                     input int unsigned sh);
        logic [67:0] mag;
        logic [67:0] half;
        logic [67:0] m;
        mag  = v[67] ? 68'(-v) : 68'(v);
        half = 68'(1) << (sh - 1);
        m    = (mag + half) >> sh;
        rnd_shift = v[67] ? -$signed(m) : $signed(m);
    endfunction

endpackage

`default_nettype wire

// File: rtl/laser_plane_ray_intersect.sv
// top level of the laser plane ray intersection block
// throughput one item per cycle while busy is low,
// set by the six-stage multiply pipeline behind a two-entry item queue
// after reset or any register write, busy stays high (longer for a small normal, which needs more
// normalize shifts) while the sequential basis unit (normalize shift, square root, three serial
// divides, four products) runs; for a degenerate plane it drops straight after the load step
// reset is asynchronous active low; registers return to normal (0,0,1), distance 0
// results cannot be stalled: each is on the ports for one cycle only
`default_nettype none

`include "laser_plane_ray_intersect_defines.svh"

module laser_plane_ray_intersect import lpri_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  ray_t                 ray,
    output logic                 result_valid,
    output point_t               point,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    // accept edge to strobe sample
    localparam int LATENCY = 7;

    coef_t coef;
    logic  coef_busy;
    logic  head_valid;
    item_t head;

    // config port always takes a write
    assign cfg_ready = 1'b1;

    // basis derivation from the plane registers
    lpri_coef u_coef (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef),
        .busy      (coef_busy)
    );

    // front: take items, tag the plane class, queue them
    lpri_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .ray        (ray),
        .deg        (coef.deg),
        .coef_busy  (coef_busy),
        .pop        (head_valid),
        .busy       (busy),
        .head_valid (head_valid),
        .head       (head)
    );

    // back: pipeline drains the queue every cycle
    lpri_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (head_valid),
        .item      (head),
        .coef      (coef),
        .out_valid (result_valid),
        .point     (point)
    );

    `LPRI_ASSERT_NEXT(a_cfg_holds_off, cfg_valid && cfg_ready, busy, "write did not hold off items")
    `LPRI_ASSERT_DELAY(a_fixed_latency, start && !busy, LATENCY, result_valid, "result missing")

endmodule

`default_nettype wire

// File: rtl/lpri_coef.sv
// configuration registers and sequential derivation of the plane basis coefficients
`default_nettype none

module lpri_coef import lpri_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output coef_t                coef,
    output logic                 busy
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_LOAD = 3'd1;
    localparam logic [2:0] ST_NORM = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_DSET = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_PROD = 3'd7;

    localparam logic [5:0]  NORM_MAX = 6'd30;
    localparam logic [5:0]  DIV_LAST = 6'd62;
    localparam logic [5:0]  PROD_LAST = 6'd4;
    localparam logic [63:0] SQRT_BIT0 = 64'h4000_0000_0000_0000;
    localparam logic [31:0] UNIT_ONE = 32'h4000_0000;

    logic signed [31:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;
    logic [30:0]        d_reg, d_next;
    logic [2:0]         state_reg, state_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [1:0]         idx_reg, idx_next;
    logic [31:0]        m_reg [3];
    logic [31:0]        m_next [3];
    logic signed [31:0] u_reg [3];
    logic signed [31:0] u_next [3];
    logic [63:0]        acc_reg, acc_next;
    logic [63:0]        root_reg, root_next;
    logic [63:0]        bit_reg, bit_next;
    logic [32:0]        rem_reg, rem_next;
    logic [62:0]        dvd_reg, dvd_next;
    logic [62:0]        quo_reg, quo_next;
    logic signed [63:0] prod_reg, prod_next;
    logic signed [63:0] psum_reg, psum_next;
    logic signed [32:0] a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic               deg_reg, deg_next;

    logic signed [31:0] n_sel;
    logic [31:0]        m_sel;
    logic [63:0]        sq_trial;
    logic [33:0]        dv_trial;
    logic [33:0]        dv_len;
    logic               dv_ge;
    logic [62:0]        q_fin;
    logic [31:0]        q_clamp;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    always_comb
    begin
        unique case (idx_reg)
            2'd0:    begin n_sel = nx_reg; m_sel = m_reg[0]; end
            2'd1:    begin n_sel = ny_reg; m_sel = m_reg[1]; end
            default: begin n_sel = nz_reg; m_sel = m_reg[2]; end
        endcase
    end

    assign sq_trial = root_reg + bit_reg;
    assign dv_trial = {rem_reg, dvd_reg[62]};
    assign dv_len   = {1'b0, root_reg[32:0]};
    assign dv_ge    = dv_trial >= dv_len;
    assign q_fin    = {quo_reg[61:0], dv_ge};
    assign q_clamp  = (q_fin > 63'(UNIT_ONE)) ? UNIT_ONE : q_fin[31:0];

    always_comb
    begin
        nx_next    = nx_reg;
        ny_next    = ny_reg;
        nz_next    = nz_reg;
        d_next     = d_reg;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        m_next     = m_reg;
        u_next     = u_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        quo_next   = quo_reg;
        prod_next  = prod_reg;
        psum_next  = psum_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        c_next     = c_reg;
        deg_next   = deg_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
            end
            ST_LOAD:
            begin
                m_next[0] = mag32(nx_reg);
                m_next[1] = mag32(ny_reg);
                m_next[2] = mag32(nz_reg);
                deg_next  = (ny_reg == 32'sd0) && (nz_reg == 32'sd0);
                cnt_next  = '0;
                state_next = ((ny_reg == 32'sd0) && (nz_reg == 32'sd0)) ? ST_IDLE : ST_NORM;
            end
            ST_NORM:
            begin
                // scale so the largest magnitude reaches 2^30
                if ((cnt_reg < NORM_MAX) && ((m_reg[0][31:30] | m_reg[1][31:30]
                                              | m_reg[2][31:30]) == 2'b00))
                begin
                    m_next[0] = m_reg[0] << 1;
                    m_next[1] = m_reg[1] << 1;
                    m_next[2] = m_reg[2] << 1;
                    cnt_next  = cnt_reg + 6'd1;
                end
                else
                begin
                    idx_next   = 2'd0;
                    acc_next   = '0;
                    state_next = ST_SQR;
                end
            end
            ST_SQR:
            begin
                acc_next = acc_reg + 64'(m_sel) * 64'(m_sel);
                if (idx_reg == 2'd2)
                begin
                    root_next  = '0;
                    bit_next   = SQRT_BIT0;
                    state_next = ST_SQRT;
                end
                else
                begin
                    idx_next = idx_reg + 2'd1;
                end
            end
            ST_SQRT:
            begin
                if (acc_reg >= sq_trial)
                begin
                    acc_next  = acc_reg - sq_trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                if (bit_reg == 64'd1)
                begin
                    idx_next   = 2'd0;
                    state_next = ST_DSET;
                end
            end
            ST_DSET:
            begin
                dvd_next   = (63'(m_sel) << UNIT_BITS) + 63'(root_reg[32:1]);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next = dv_ge ? 33'(dv_trial - dv_len) : dv_trial[32:0];
                quo_next = q_fin;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    unique case (idx_reg)
                        2'd0:    u_next[0] = n_sel[31] ? -$signed(q_clamp) : $signed(q_clamp);
                        2'd1:    u_next[1] = n_sel[31] ? -$signed(q_clamp) : $signed(q_clamp);
                        default: u_next[2] = n_sel[31] ? -$signed(q_clamp) : $signed(q_clamp);
                    endcase
                    cnt_next = '0;
                    if (idx_reg == 2'd2)
                    begin
                        state_next = ST_PROD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 2'd1;
                        state_next = ST_DSET;
                    end
                end
            end
            default:
            begin
                // ST_PROD: one product per step, then a last step that rounds c
                cnt_next = cnt_reg + 6'd1;
                unique case (cnt_reg[2:0])
                    3'd0: prod_next = 64'(u_reg[1]) * 64'(u_reg[1]);
                    3'd1:
                    begin
                        psum_next = prod_reg;
                        prod_next = 64'(u_reg[2]) * 64'(u_reg[2]);
                    end
                    3'd2:
                    begin
                        a_next = 33'(rnd_shift(68'(psum_reg) + 68'(prod_reg), UNIT_BITS));
                        prod_next = 64'(u_reg[0]) * 64'(u_reg[1]);
                    end
                    3'd3:
                    begin
                        b_next = 33'(rnd_shift(68'(prod_reg), UNIT_BITS));
                        prod_next = 64'(u_reg[0]) * 64'(u_reg[2]);
                    end
                    default:
                    begin
                        c_next = 33'(rnd_shift(68'(prod_reg), UNIT_BITS));
                    end
                endcase
                if (cnt_reg == PROD_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase

        // a register write restarts the derivation
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NORMAL_X: nx_next = cfg_data;
                CFG_NORMAL_Y: ny_next = cfg_data;
                CFG_NORMAL_Z: nz_next = cfg_data;
                default:      d_next  = cfg_data[30:0];
            endcase
            state_next = ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg    <= 32'sd0;
            ny_reg    <= 32'sd0;
            nz_reg    <= 32'sd65536;
            d_reg     <= '0;
            state_reg <= ST_LOAD;
        end
        else
        begin
            nx_reg    <= nx_next;
            ny_reg    <= ny_next;
            nz_reg    <= nz_next;
            d_reg     <= d_next;
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        idx_reg  <= idx_next;
        m_reg    <= m_next;
        u_reg    <= u_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        rem_reg  <= rem_next;
        dvd_reg  <= dvd_next;
        quo_reg  <= quo_next;
        prod_reg <= prod_next;
        psum_reg <= psum_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        deg_reg  <= deg_next;
    end

    assign busy = state_reg != ST_IDLE;

    always_comb
    begin
        coef.a        = a_reg;
        coef.b        = b_reg;
        coef.c        = c_reg;
        coef.u1       = u_reg[1];
        coef.u2       = u_reg[2];
        coef.distance = d_reg;
        coef.deg      = deg_reg;
    end

endmodule

`default_nettype wire

// File: rtl/lpri_queue.sv
// front end: accepts items, tags degenerate planes and buffers them for the datapath
`default_nettype none

module lpri_queue import lpri_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  ray_t  ray,
    input  logic  deg,
    input  logic  coef_busy,
    input  logic  pop,
    output logic  busy,
    output logic  head_valid,
    output item_t head
);

    item_t                mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_PTR_W:0]     cnt_reg, cnt_next;
    logic                 push;
    logic                 do_pop;

    assign busy       = coef_busy || (cnt_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign push       = start && !busy;
    assign head_valid = cnt_reg != '0;
    assign do_pop     = pop && head_valid;
    assign head       = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (Q_PTR_W+1)'(push) - (Q_PTR_W+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= '{ray: ray, deg: deg};
        end
    end

endmodule

`default_nettype wire

// File: rtl/lpri_back.sv
// back end: six-stage pipeline forming the intersection point from the coefficients
`default_nettype none

module lpri_back import lpri_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    input  item_t  item,
    input  coef_t  coef,
    output logic   out_valid,
    output point_t point
);

    localparam logic signed [67:0] LIM_POS = 68'sh7FFF_FFFF;
    localparam logic signed [67:0] LIM_NEG = -68'sh8000_0000;

    logic [5:0]         v_reg;
    logic [4:0]         deg_reg;

    logic signed [64:0] pxa_reg, pxb_reg, pyu2_reg, pxc_reg, pyu1_reg;
    logic signed [65:0] s0_reg, s1_reg, s2_reg;
    logic signed [35:0] q0_reg, q1_reg, q2_reg;
    logic signed [67:0] pd0_reg, pd1_reg, pd2_reg;
    logic signed [67:0] r0_reg, r1_reg, r2_reg;
    point_t             point_reg, point_next;

    logic signed [67:0] dist_s;

    assign dist_s = $signed({37'd0, coef.distance});

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        if (v > LIM_POS)
        begin
            sat32 = SAT_POS;
        end
        else if (v < LIM_NEG)
        begin
            sat32 = SAT_NEG;
        end
        else
        begin
            sat32 = v[31:0];
        end
    endfunction

    always_comb
    begin
        if (deg_reg[4])
        begin
            point_next = '{point_x: SAT_POS, point_y: SAT_POS, point_z: SAT_POS,
                           overflow: 1'b1};
        end
        else
        begin
            point_next.point_x  = sat32(r0_reg);
            point_next.point_y  = sat32(r1_reg);
            point_next.point_z  = sat32(r2_reg);
            point_next.overflow = (r0_reg > LIM_POS) || (r0_reg < LIM_NEG)
                               || (r1_reg > LIM_POS) || (r1_reg < LIM_NEG)
                               || (r2_reg > LIM_POS) || (r2_reg < LIM_NEG);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: ray times coefficients
        pxa_reg  <= 65'(item.ray.ray_x) * 65'(coef.a);
        pxb_reg  <= 65'(item.ray.ray_x) * 65'(coef.b);
        pyu2_reg <= 65'(item.ray.ray_y) * 65'(coef.u2);
        pxc_reg  <= 65'(item.ray.ray_x) * 65'(coef.c);
        pyu1_reg <= 65'(item.ray.ray_y) * 65'(coef.u1);
        deg_reg  <= {deg_reg[3:0], item.deg};
        // stage 2: bracket sums
        s0_reg <= 66'(pxa_reg);
        s1_reg <= 66'(pxb_reg) - 66'(pyu2_reg);
        s2_reg <= 66'(pxc_reg) + 66'(pyu1_reg);
        // stage 3: back to the pixel format
        q0_reg <= 36'(-rnd_shift(68'(s0_reg), UNIT_BITS));
        q1_reg <= 36'(rnd_shift(68'(s1_reg), UNIT_BITS));
        q2_reg <= 36'(rnd_shift(68'(s2_reg), UNIT_BITS));
        // stage 4: scale by plane distance
        pd0_reg <= 68'(q0_reg) * dist_s;
        pd1_reg <= 68'(q1_reg) * dist_s;
        pd2_reg <= 68'(q2_reg) * dist_s;
        // stage 5: drop the extra fraction
        r0_reg <= rnd_shift(pd0_reg, FRAC_BITS);
        r1_reg <= rnd_shift(pd1_reg, FRAC_BITS);
        r2_reg <= rnd_shift(pd2_reg, FRAC_BITS);
        // stage 6: saturate
        point_reg <= point_next;
    end

    assign out_valid = v_reg[5];
    assign point     = point_reg;

endmodule

`default_nettype wire
